[rtl/core/bcf_pkg.sv]
// Shared types and constants of the cubic Bezier fade generator.
// No dependencies; every other file of the block imports this package.
package bcf_pkg;

  localparam int unsigned FADE_STEPS_DEF  = 255;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned PERIOD_W    = 24;
  localparam int unsigned WEIGHT_W    = 15;
  localparam int unsigned WEIGHT_FRAC = 14;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [LEVEL_W-1:0]  START_LEVEL_RST = 8'd0;
  localparam logic [LEVEL_W-1:0]  END_LEVEL_RST   = 8'd255;
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 24'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_A_RST    = 15'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B_RST    = 15'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_C_RST    = 15'd16384;
  localparam logic [WEIGHT_W-1:0] WEIGHT_D_RST    = 15'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL = 3'd0,
    REG_END_LEVEL   = 3'd1,
    REG_STEP_PERIOD = 3'd2,
    REG_WEIGHT_A    = 3'd3,
    REG_WEIGHT_B    = 3'd4,
    REG_WEIGHT_C    = 3'd5,
    REG_WEIGHT_D    = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_CUBE,
    BK_WEIGHT,
    BK_SUM,
    BK_SCALE,
    BK_TOTAL,
    BK_DIVIDE,
    BK_CORRECT,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  start_level;
    logic [LEVEL_W-1:0]  end_level;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic [WEIGHT_W-1:0] weight_d;
  } curve_cfg_t;

endpackage

[rtl/core/bcf_front.sv]
// Front end of the fade generator: prescaler, step counter and run flag.
// Every accepted tick leaves its step number in the queue. Uses bcf_pkg.
module bcf_front #(
  parameter int unsigned FadeSteps = bcf_pkg::FADE_STEPS_DEF,
  localparam int unsigned StepW = $clog2(FadeSteps + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         restart_i,
  input  logic [bcf_pkg::PERIOD_W-1:0] step_period_i,
  output logic                         wr_o,
  output logic [StepW-1:0]             step_o
);
  import bcf_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(FadeSteps);

  logic [StepW-1:0]    step_q, step_d;
  logic [PERIOD_W-1:0] pre_q, pre_d;
  logic                run_q, run_d;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] pre_inc;

  // A period of zero behaves like one.
  assign period_eff = (step_period_i == '0) ? PERIOD_W'(1) : step_period_i;
  assign pre_inc    = pre_q + PERIOD_W'(1);

  always_comb begin
    step_d = step_q;
    pre_d  = pre_q;
    run_d  = run_q;
    if (accept_i) begin
      if (restart_i) begin
        step_d = '0;
        pre_d  = '0;
        run_d  = 1'b1;
      end else if (run_q) begin
        if (pre_inc >= period_eff) begin
          pre_d  = '0;
          step_d = step_q + StepW'(1);
          if (step_d >= LastStep) begin
            step_d = LastStep;
            run_d  = 1'b0;
          end
        end else begin
          pre_d = pre_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      pre_q  <= '0;
      run_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      pre_q  <= pre_d;
      run_q  <= run_d;
    end
  end

  assign wr_o   = accept_i;
  assign step_o = step_d;

endmodule

[rtl/core/bcf_queue.sv]
// Short first-in first-out queue of step numbers between front and back.
// Takes its default depth from bcf_pkg, which it also imports.
module bcf_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = bcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_i,
  output logic             valid_o,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o
);
  import bcf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] data_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = data_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      data_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/core/bcf_back.sv]
// Back end of the fade generator: evaluates the Bezier level of one step
// with a multiply sequence and a reciprocal division. Uses bcf_pkg.
module bcf_back #(
  parameter int unsigned FadeSteps = bcf_pkg::FADE_STEPS_DEF,
  localparam int unsigned StepW = $clog2(FadeSteps + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcf_pkg::curve_cfg_t         cfg_i,
  input  logic                        q_valid_i,
  input  logic [StepW-1:0]            q_step_i,
  output logic                        q_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [bcf_pkg::LEVEL_W-1:0] level_o,
  output logic [bcf_pkg::LEVEL_W-1:0] step_index_o,
  output logic                        done_res_o
);
  import bcf_pkg::*;

  localparam int unsigned SqW   = 2 * StepW;
  localparam int unsigned TriW  = 3 * StepW;
  localparam int unsigned CubeW = 3 * StepW + 2;
  localparam int unsigned AccW  = 3 * StepW + WEIGHT_W + 2;
  localparam int unsigned TotW  = AccW + LEVEL_W + 2;
  localparam int unsigned XW    = 3 * StepW + LEVEL_W;
  localparam int unsigned RcpW  = LEVEL_W + 1;
  localparam int unsigned ProdW = XW + RcpW;
  localparam longint unsigned CubeVal =
    longint'(FadeSteps) * FadeSteps * FadeSteps;
  localparam longint unsigned DenVal = CubeVal * (64'd1 << WEIGHT_FRAC);
  localparam int unsigned     RcpSh  = LEVEL_W + $clog2(CubeVal);
  localparam longint unsigned RcpVal = (64'd1 << RcpSh) / CubeVal;
  localparam logic [XW-1:0]          CubeC    = XW'(CubeVal);
  localparam logic [RcpW-1:0]        RcpC     = RcpW'(RcpVal);
  localparam logic signed [TotW-1:0] SatLimit = TotW'(DenVal << LEVEL_W);
  localparam logic [StepW-1:0]       LastStep = StepW'(FadeSteps);

  back_state_e state_q, state_d;

  logic [StepW-1:0]      t_q, t_d, u_q, u_d;
  logic [SqW-1:0]        uu_q, uu_d, tt_q, tt_d;
  logic [CubeW-1:0]      c_q [4];
  logic [CubeW-1:0]      c_d [4];
  logic [AccW-1:0]       p_q [4];
  logic [AccW-1:0]       p_d [4];
  logic [WEIGHT_W-1:0]   w [4];
  logic [AccW-1:0]       bnum_q, bnum_d;
  logic signed [TotW-1:0] prod_q, prod_d, base_q, base_d;
  logic signed [TotW-1:0] total;
  logic signed [LEVEL_W:0] delta;
  logic [XW-1:0]         x_q, x_d, rem_est;
  logic [ProdW-1:0]      rcp_prod;
  logic [LEVEL_W-1:0]    quo_q, quo_d;
  logic [TriW-1:0]       m_uut, m_utt;
  logic                  out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]    level_q, level_d, step_out_q, step_out_d;
  logic                  done_q, done_d;
  logic                  out_free;

  assign w[0] = cfg_i.weight_a;
  assign w[1] = cfg_i.weight_b;
  assign w[2] = cfg_i.weight_c;
  assign w[3] = cfg_i.weight_d;

  assign m_uut    = TriW'(uu_q) * TriW'(t_q);
  assign m_utt    = TriW'(tt_q) * TriW'(u_q);
  assign delta    = $signed({1'b0, cfg_i.end_level}) - $signed({1'b0, cfg_i.start_level});
  assign total    = base_q + prod_q;
  assign rcp_prod = ProdW'(x_q) * ProdW'(RcpC);
  assign rem_est  = x_q - XW'(quo_q) * CubeC;
  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    u_d         = u_q;
    uu_d        = uu_q;
    tt_d        = tt_q;
    c_d         = c_q;
    p_d         = p_q;
    bnum_d      = bnum_q;
    prod_d      = prod_q;
    base_d      = base_q;
    x_d         = x_q;
    quo_d       = quo_q;
    level_d     = level_q;
    step_out_d  = step_out_q;
    done_d      = done_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          t_d     = q_step_i;
          u_d     = LastStep - q_step_i;
          state_d = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        uu_d    = SqW'(u_q) * SqW'(u_q);
        tt_d    = SqW'(t_q) * SqW'(t_q);
        state_d = BK_CUBE;
      end
      BK_CUBE: begin
        // Bernstein factors: u^3, 3u^2t, 3ut^2, t^3.
        c_d[0]  = CubeW'(uu_q) * CubeW'(u_q);
        c_d[1]  = (CubeW'(m_uut) << 1) + CubeW'(m_uut);
        c_d[2]  = (CubeW'(m_utt) << 1) + CubeW'(m_utt);
        c_d[3]  = CubeW'(tt_q) * CubeW'(t_q);
        state_d = BK_WEIGHT;
      end
      BK_WEIGHT: begin
        for (int k = 0; k < 4; k++) begin
          p_d[k] = AccW'(c_q[k]) * AccW'(w[k]);
        end
        state_d = BK_SUM;
      end
      BK_SUM: begin
        bnum_d  = (p_q[0] + p_q[1]) + (p_q[2] + p_q[3]);
        state_d = BK_SCALE;
      end
      BK_SCALE: begin
        prod_d  = TotW'(delta) * TotW'($signed({1'b0, bnum_q}));
        base_d  = $signed(TotW'(cfg_i.start_level) * TotW'(DenVal));
        state_d = BK_TOTAL;
      end
      BK_TOTAL: begin
        // The fraction bits of the denominator drop out as a plain shift.
        x_d   = XW'(total >>> WEIGHT_FRAC);
        quo_d = '0;
        if (total <= 0) begin
          state_d = BK_FINISH;
        end else if (total >= SatLimit) begin
          quo_d   = '1;
          state_d = BK_FINISH;
        end else begin
          state_d = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        quo_d   = LEVEL_W'(rcp_prod >> RcpSh);
        state_d = BK_CORRECT;
      end
      BK_CORRECT: begin
        // The reciprocal estimate is at most one below the true quotient.
        if (rem_est >= CubeC) begin
          quo_d = quo_q + LEVEL_W'(1);
        end
        state_d = BK_FINISH;
      end
      BK_FINISH: begin
        if (out_free) begin
          level_d     = quo_q;
          step_out_d  = LEVEL_W'(t_q);
          done_d      = (t_q >= LastStep);
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    u_q        <= u_d;
    uu_q       <= uu_d;
    tt_q       <= tt_d;
    c_q        <= c_d;
    p_q        <= p_d;
    bnum_q     <= bnum_d;
    prod_q     <= prod_d;
    base_q     <= base_d;
    x_q        <= x_d;
    quo_q      <= quo_d;
    level_q    <= level_d;
    step_out_q <= step_out_d;
    done_q     <= done_d;
  end

  assign empty_o      = !out_valid_q;
  assign level_o      = level_q;
  assign step_index_o = step_out_q;
  assign done_res_o   = done_q;

endmodule

[rtl/core/cubic_bezier_fade_generator_top.sv]
// Cubic Bezier fade generator, top level with the configuration registers.
// Depends on bcf_pkg, bcf_front, bcf_queue and bcf_back.
//
// Each accepted beat is one timer tick (restart_i high starts a new fade at
// step zero) and yields one result beat with the level, the step number and
// the done flag. The front end updates the prescaler and step counter in the
// cycle a tick is accepted and queues the step number; the back end takes one
// step at a time: it pops it, forms the Bernstein products and the signed
// total, divides the total by the constant denominator with a reciprocal
// multiply and one correction, and hands the result to the output register.
// When the level saturates or is zero the division is skipped. A new step is
// taken only after the last result has reached the output register, and the
// back end waits while a result beat waits to be popped. The queue holds
// QueueDepth ticks besides the one in the back end; full rises when it is
// filled. Configuration must be written while no tick is outstanding.
module cubic_bezier_fade_generator_top #(
  parameter int unsigned FadeSteps  = bcf_pkg::FADE_STEPS_DEF,
  parameter int unsigned QueueDepth = bcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           restart_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [bcf_pkg::LEVEL_W-1:0]    level_o,
  output logic [bcf_pkg::LEVEL_W-1:0]    step_index_o,
  output logic                           done_res_o
);
  import bcf_pkg::*;

  localparam int unsigned StepW = $clog2(FadeSteps + 1);

  curve_cfg_t          curve_q;
  logic [PERIOD_W-1:0] step_period_q;
  logic                accept;
  logic                q_wr, q_pop, q_valid;
  logic [StepW-1:0]    q_wr_step, q_rd_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q.start_level <= START_LEVEL_RST;
      curve_q.end_level   <= END_LEVEL_RST;
      curve_q.weight_a    <= WEIGHT_A_RST;
      curve_q.weight_b    <= WEIGHT_B_RST;
      curve_q.weight_c    <= WEIGHT_C_RST;
      curve_q.weight_d    <= WEIGHT_D_RST;
      step_period_q       <= STEP_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_START_LEVEL: curve_q.start_level <= cfg_data_i[LEVEL_W-1:0];
        REG_END_LEVEL:   curve_q.end_level   <= cfg_data_i[LEVEL_W-1:0];
        REG_STEP_PERIOD: step_period_q       <= cfg_data_i[PERIOD_W-1:0];
        REG_WEIGHT_A:    curve_q.weight_a    <= cfg_data_i[WEIGHT_W-1:0];
        REG_WEIGHT_B:    curve_q.weight_b    <= cfg_data_i[WEIGHT_W-1:0];
        REG_WEIGHT_C:    curve_q.weight_c    <= cfg_data_i[WEIGHT_W-1:0];
        REG_WEIGHT_D:    curve_q.weight_d    <= cfg_data_i[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  bcf_front #(
    .FadeSteps(FadeSteps)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .restart_i    (restart_i),
    .step_period_i(step_period_q),
    .wr_o         (q_wr),
    .step_o       (q_wr_step)
  );

  bcf_queue #(
    .Width(StepW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_data_i(q_wr_step),
    .rd_i     (q_pop),
    .valid_o  (q_valid),
    .rd_data_o(q_rd_step),
    .full_o   (full)
  );

  bcf_back #(
    .FadeSteps(FadeSteps)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (curve_q),
    .q_valid_i   (q_valid),
    .q_step_i    (q_rd_step),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .level_o     (level_o),
    .step_index_o(step_index_o),
    .done_res_o  (done_res_o)
  );

endmodule

[rtl/core/bcf_checker.sv]
// Port-level checks for the fade generator, bound to the top level.
// Depends on cubic_bezier_fade_generator_top and bcf_pkg.
module bcf_checker #(
  parameter int unsigned FadeSteps = bcf_pkg::FADE_STEPS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [bcf_pkg::LEVEL_W-1:0] level_o,
  input logic [bcf_pkg::LEVEL_W-1:0] step_index_o,
  input logic                        done_res_o
);
  import bcf_pkg::*;

  localparam logic [LEVEL_W-1:0] LastIndex = LEVEL_W'(FadeSteps);
  localparam logic               NarrowSteps = (FadeSteps <= 255);

  // A waiting beat that is not taken stays as it is.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(level_o) && $stable(step_index_o)
                       && $stable(done_res_o))
    else $error("result beat changed while waiting");

  // A finished fade always reports the last step.
  a_done_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && done_res_o |-> step_index_o == LastIndex)
    else $error("done flag with a step other than the last");

  // When the step numbers fit the output, the last step must carry the done flag.
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NarrowSteps && !empty && !done_res_o |-> step_index_o != LastIndex)
    else $error("last step reported without the done flag");

endmodule

bind cubic_bezier_fade_generator_top bcf_checker #(
  .FadeSteps(FadeSteps)
) u_bcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .level_o     (level_o),
  .step_index_o(step_index_o),
  .done_res_o  (done_res_o)
);
